[rtl/vwna_pkg.sv]
// ----------------------------------------------------------------------------
// vwna_pkg
// Shared types and constants for the vertex weld / normal averaging table.
// ----------------------------------------------------------------------------
package vwna_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // One table entry as held in the memory
  typedef struct packed {
    logic [15:0]              cnt;
    logic [2:0][31:0]         sum;   // signed normal sums, x in [0]
    logic [2:0][31:0]         pos;   // raw float32 bits, x in [0]
  } entry_t;

endpackage

[rtl/vwna_div.sv]
// ----------------------------------------------------------------------------
// vwna_div
// Three-lane signed-by-unsigned restoring divider, one quotient bit per cycle.
// All lanes share the divisor; quotients truncate toward zero.
// ----------------------------------------------------------------------------
module vwna_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0][31:0] num,   // signed numerators
  input  logic [15:0]      den,   // nonzero divisor
  output logic             done,
  output logic [2:0][15:0] quo    // signed quotients, low 16 bits
);

  logic [5:0]        step;
  logic              busy;
  logic [15:0]       dreg;
  logic [2:0][31:0]  mag;
  logic [2:0][15:0]  rem;
  logic [2:0]        neg;
  logic [2:0][16:0]  shv;
  logic [2:0]        qbit;
  logic [2:0][31:0]  qfin;

  // one restoring step per lane
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      shv[k]  = {rem[k], mag[k][31]};
      qbit[k] = (shv[k] >= {1'b0, dreg});
      qfin[k] = neg[k] ? (32'd0 - mag[k]) : mag[k];
      quo[k]  = qfin[k][15:0];
    end
  end

  // iteration control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        dreg <= den;
        for (int k = 0; k < 3; k++) begin
          neg[k] <= num[k][31];
          mag[k] <= num[k][31] ? (32'd0 - num[k]) : num[k];
          rem[k] <= '0;
        end
      end else if (busy) begin
        for (int k = 0; k < 3; k++) begin
          if (qbit[k]) begin
            rem[k] <= 16'(shv[k] - {1'b0, dreg});
          end else begin
            rem[k] <= shv[k][15:0];
          end
          mag[k] <= {mag[k][30:0], qbit[k]};
        end
        step <= step + 6'd1;
        if (step == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/vertex_weld_normal_average.sv]
// ----------------------------------------------------------------------------
// vertex_weld_normal_average
// Vertex welding table with normal sum accumulation and averaged readback.
// ----------------------------------------------------------------------------
// One item is handled at a time. A record beat scans the stored positions
// through a synchronous memory with one read and one write port, one entry
// per cycle. A record then writes the updated or new entry (a hit with a
// saturated count is not written), runs the bit-serial divider that forms
// the averaged normal, loads the output and goes back to idle. A record that
// hits ends the scan early; a record into an empty table skips the scan. A
// read beat within the fill level fetches the entry and runs the divider;
// clear, no-op and out-of-range read beats go straight to the output. An
// overflowing record skips the divider. The table memory is never cleared;
// entries above the fill level are simply never looked at.
module vertex_weld_normal_average #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // fields low to high: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
  // read_index, zero pad
  input  logic [159:0] s_axis_tdata,
  // fields: op
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // fields low to high: entry_index, is_new, overflow, out_pos_x, out_pos_y,
  // out_pos_z, avg_norm_x, avg_norm_y, avg_norm_z, share_count,
  // entries_used, zero pad
  output logic [183:0] m_axis_tdata
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_UPD, S_RDA, S_RDW, S_DIV, S_DONE
  } state_t;

  state_t               state;
  vwna_pkg::op_t        op;
  logic [FW-1:0]        fill;
  logic [FW-1:0]        scan;
  logic                 rd_vld;
  logic [IW-1:0]        rd_idx;
  logic                 hit;
  logic [IW-1:0]        res_idx;
  logic                 res_new, res_ovf, res_zero;
  logic [2:0][31:0]     pos;
  logic [2:0][15:0]     nrm;
  logic [9:0]           ridx;
  vwna_pkg::entry_t     ent;
  logic                 div_go, div_done;
  logic [2:0][15:0]     quo;

  // table memory
  vwna_pkg::entry_t     mem [TABLE_DEPTH];
  vwna_pkg::entry_t     rdata, wdata;
  logic                 ren, wen;
  logic [IW-1:0]        raddr, waddr;

  logic                 match, last;
  logic                 can_add;

  assign match = (rdata.pos == pos);
  assign last  = (rd_idx == IW'(fill - FW'(1)));
  assign can_add = (rdata.cnt != vwna_pkg::COUNT_MAX);

  // read port: scan during search, single read for a read beat
  always_comb begin
    ren   = 1'b0;
    raddr = IW'(scan);
    if (state == S_SRCH) begin
      ren = !(rd_vld && (match || last)) && (scan < fill);
    end else if (state == S_RDA) begin
      ren   = 1'b1;
      raddr = IW'(ridx);
    end
  end

  // write port: update on hit, append on miss
  always_comb begin
    wen   = 1'b0;
    waddr = rd_idx;
    wdata = rdata;
    if (state == S_UPD) begin
      if (hit) begin
        wen = can_add;
        for (int k = 0; k < 3; k++) begin
          wdata.sum[k] = rdata.sum[k] + {{16{nrm[k][15]}}, nrm[k]};
        end
        wdata.cnt = rdata.cnt + 16'd1;
      end else begin
        wen   = (fill < FW'(TABLE_DEPTH));
        waddr = IW'(fill);
        wdata.pos = pos;
        for (int k = 0; k < 3; k++) begin
          wdata.sum[k] = {{16{nrm[k][15]}}, nrm[k]};
        end
        wdata.cnt = 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

  vwna_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (ent.sum),
    .den   (ent.cnt),
    .done  (div_done),
    .quo   (quo)
  );

  assign s_axis_tready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fill          <= '0;
      rd_vld        <= 1'b0;
      div_go        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op       <= vwna_pkg::op_t'(s_axis_tuser);
            pos[0]   <= s_axis_tdata[31:0];
            pos[1]   <= s_axis_tdata[63:32];
            pos[2]   <= s_axis_tdata[95:64];
            nrm[0]   <= s_axis_tdata[111:96];
            nrm[1]   <= s_axis_tdata[127:112];
            nrm[2]   <= s_axis_tdata[143:128];
            ridx     <= s_axis_tdata[153:144];
            res_new  <= 1'b0;
            res_ovf  <= 1'b0;
            res_zero <= 1'b1;
            res_idx  <= '0;
            case (vwna_pkg::op_t'(s_axis_tuser))
              vwna_pkg::OP_RECORD: begin
                scan   <= '0;
                rd_vld <= 1'b0;
                hit    <= 1'b0;
                state  <= (fill == '0) ? S_UPD : S_SRCH;
              end
              vwna_pkg::OP_READ: begin
                res_idx <= IW'(s_axis_tdata[153:144]);
                if (32'(s_axis_tdata[153:144]) < 32'(fill)) begin
                  state <= S_RDA;
                end else begin
                  state <= S_DONE;
                end
              end
              vwna_pkg::OP_CLEAR: begin
                fill  <= '0;
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SRCH: begin
          rd_vld <= ren;
          if (ren) begin
            rd_idx <= IW'(scan);
            scan   <= scan + FW'(1);
          end
          if (rd_vld && match) begin
            hit   <= 1'b1;
            state <= S_UPD;
          end else if (rd_vld && last) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (hit) begin
            ent      <= can_add ? wdata : rdata;
            res_idx  <= rd_idx;
            res_zero <= 1'b0;
            div_go   <= 1'b1;
            state    <= S_DIV;
          end else if (fill < FW'(TABLE_DEPTH)) begin
            ent      <= wdata;
            res_idx  <= IW'(fill);
            res_new  <= 1'b1;
            res_zero <= 1'b0;
            fill     <= fill + FW'(1);
            div_go   <= 1'b1;
            state    <= S_DIV;
          end else begin
            res_ovf <= 1'b1;
            state   <= S_DONE;
          end
        end
        S_RDA: begin
          state <= S_RDW;
        end
        S_RDW: begin
          ent      <= rdata;
          res_zero <= 1'b0;
          div_go   <= 1'b1;
          state    <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {1'b0, 11'(fill),
                              res_zero ? 160'd0 : {ent.cnt, quo, ent.pos},
                              res_ovf, res_new,
                              (op == vwna_pkg::OP_READ) ? ridx : 10'(res_idx)};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the vertex weld / normal averaging table. Beats are
// predicted by a behavioral copy of the table. Each output beat is compared
// field by field against the oldest prediction. The bench runs directed
// cases, back pressure and random traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH      = 1024;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    vwna_pkg::op_t      op;
    logic [31:0]        px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [9:0]         ridx;
  } vertex_beat_t;

  typedef struct {
    logic [9:0]  idx;
    logic        is_new, ovf;
    logic [31:0] px, py, pz;
    logic [15:0] ax, ay, az;
    logic [15:0] cnt;
    logic [10:0] used;
  } weld_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [183:0] m_axis_tdata;

  // Table copy used for prediction
  logic [31:0]  pos_copy [DEPTH][3];
  int           sum_copy [DEPTH][3];
  int unsigned  cnt_copy [DEPTH];
  int unsigned  fill_copy;

  weld_result_t pending_results[$];
  int           errors      = 0;
  int           idle_pct    = 0;
  int           stall_pct   = 0;
  int           hold_cycles = 0;
  int           quiet_cycles = 0;
  logic [31:0]  pos_pool [24][3];

  // Sampled handshakes (taken with pre-edge values)
  logic         in_fire  = 1'b0;
  logic         out_fire = 1'b0;
  logic [183:0] out_beat = '0;

  always #1 clk = ~clk;

  vertex_weld_normal_average #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always @(posedge clk) begin
    in_fire  <= s_axis_tvalid && s_axis_tready;
    out_fire <= m_axis_tvalid && m_axis_tready;
    out_beat <= m_axis_tdata;
  end

  // Receiver: long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles  <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom % 100) >= stall_pct;
    end
  end

  // Watchdog on cycles with no beat moving
  always @(negedge clk) begin
    if (in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", field, got, want);
    errors++;
  endtask

  // Output checker
  always @(negedge clk) begin
    weld_result_t got, want;
    if (out_fire) begin
      got.idx    = out_beat[9:0];
      got.is_new = out_beat[10];
      got.ovf    = out_beat[11];
      got.px     = out_beat[43:12];
      got.py     = out_beat[75:44];
      got.pz     = out_beat[107:76];
      got.ax     = out_beat[123:108];
      got.ay     = out_beat[139:124];
      got.az     = out_beat[155:140];
      got.cnt    = out_beat[171:156];
      got.used   = out_beat[182:172];
      if (pending_results.size() == 0) begin
        $display("unexpected output beat %h", out_beat);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.idx    !== want.idx)    report("entry_index",  got.idx,    want.idx);
        if (got.is_new !== want.is_new) report("is_new",       got.is_new, want.is_new);
        if (got.ovf    !== want.ovf)    report("overflow",     got.ovf,    want.ovf);
        if (got.px     !== want.px)     report("out_pos_x",    got.px,     want.px);
        if (got.py     !== want.py)     report("out_pos_y",    got.py,     want.py);
        if (got.pz     !== want.pz)     report("out_pos_z",    got.pz,     want.pz);
        if (got.ax     !== want.ax)     report("avg_norm_x",   got.ax,     want.ax);
        if (got.ay     !== want.ay)     report("avg_norm_y",   got.ay,     want.ay);
        if (got.az     !== want.az)     report("avg_norm_z",   got.az,     want.az);
        if (got.cnt    !== want.cnt)    report("share_count",  got.cnt,    want.cnt);
        if (got.used   !== want.used)   report("entries_used", got.used,   want.used);
      end
    end
  end

  // Position and averaged normal of one entry
  function automatic void load_entry(inout weld_result_t r, input int unsigned e);
    int avg [3];
    for (int k = 0; k < 3; k++) begin
      avg[k] = (cnt_copy[e] != 0) ? sum_copy[e][k] / int'(cnt_copy[e]) : 0;
    end
    r.px  = pos_copy[e][0];
    r.py  = pos_copy[e][1];
    r.pz  = pos_copy[e][2];
    r.ax  = avg[0][15:0];
    r.ay  = avg[1][15:0];
    r.az  = avg[2][15:0];
    r.cnt = cnt_copy[e][15:0];
  endfunction

  // Weld / read / clear prediction; updates the table copy
  function automatic weld_result_t weld_predict(input vertex_beat_t b);
    weld_result_t r;
    int           hit_at;
    logic [31:0]  p [3];
    int           n [3];
    r = '{default: '0};
    hit_at = -1;
    p = '{b.px, b.py, b.pz};
    n = '{int'(b.nx), int'(b.ny), int'(b.nz)};
    case (b.op)
      vwna_pkg::OP_RECORD: begin
        for (int i = 0; i < fill_copy; i++) begin
          if (hit_at < 0 && pos_copy[i][0] == p[0] && pos_copy[i][1] == p[1] &&
              pos_copy[i][2] == p[2]) hit_at = i;
        end
        if (hit_at >= 0) begin
          if (cnt_copy[hit_at] < 65535) begin
            for (int k = 0; k < 3; k++) sum_copy[hit_at][k] += n[k];
            cnt_copy[hit_at]++;
          end
          r.idx = hit_at[9:0];
          load_entry(r, hit_at);
        end else if (fill_copy < DEPTH) begin
          for (int k = 0; k < 3; k++) begin
            pos_copy[fill_copy][k] = p[k];
            sum_copy[fill_copy][k] = n[k];
          end
          cnt_copy[fill_copy] = 1;
          r.idx    = fill_copy[9:0];
          r.is_new = 1'b1;
          load_entry(r, fill_copy);
          fill_copy++;
        end else begin
          r.ovf = 1'b1;
        end
      end
      vwna_pkg::OP_READ: begin
        r.idx = b.ridx;
        if (b.ridx < fill_copy) load_entry(r, b.ridx);
      end
      vwna_pkg::OP_CLEAR: fill_copy = 0;
      default: ;
    endcase
    r.used = fill_copy[10:0];
    return r;
  endfunction

  // Send one beat; called and returns at a falling edge, tvalid left high
  task automatic send_beat(input vertex_beat_t b);
    while (($urandom % 100) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= b.op;
    s_axis_tdata  <= {6'b0, b.ridx, b.nz, b.ny, b.nx, b.pz, b.py, b.px};
    do @(negedge clk); while (!in_fire);
    pending_results = {pending_results, weld_predict(b)};
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic vertex_beat_t make_beat(input vwna_pkg::op_t op, input logic [31:0] x,
                                             input logic [31:0] y, input logic [31:0] z,
                                             input logic [15:0] nx, input logic [15:0] ny,
                                             input logic [15:0] nz, input logic [9:0] ridx);
    vertex_beat_t b;
    b = '{op, x, y, z, nx, ny, nz, ridx};
    return b;
  endfunction

  function automatic vertex_beat_t random_beat;
    vertex_beat_t b;
    int           sel, pick;
    sel  = $urandom_range(0, 99);
    pick = $urandom_range(0, 23);
    b = make_beat(vwna_pkg::OP_RECORD, pos_pool[pick][0], pos_pool[pick][1],
                  pos_pool[pick][2], 16'($urandom), 16'($urandom), 16'($urandom),
                  10'($urandom));
    if (sel < 8) begin
      // fresh position, grows the table
      b.px = $urandom; b.py = $urandom; b.pz = $urandom;
    end else if (sel < 60) begin
      // record against the pool
    end else if (sel < 85) begin
      b.op   = vwna_pkg::OP_READ;
      b.ridx = (fill_copy > 0) ? 10'($urandom_range(0, fill_copy - 1)) : 10'd0;
    end else if (sel < 92) begin
      b.op = vwna_pkg::OP_READ;
    end else if (sel < 95) begin
      b.op = vwna_pkg::OP_CLEAR;
    end else begin
      b.op = vwna_pkg::OP_NONE;
    end
    return b;
  endfunction

  // Signed zeros, NaN patterns, normal extremes, reads in and out of range, a no-op and a clear
  task automatic test_directed;
    send_beat(make_beat(vwna_pkg::OP_RECORD, 32'h0, 32'h0, 32'h0, 16'h7FFF, 16'h8000,
                        16'h0, 10'd0));
    send_beat(make_beat(vwna_pkg::OP_RECORD, 32'h8000_0000, 32'h0, 32'h0, 16'h8000,
                        16'h7FFF, 16'hFFFF, 10'd0));
    send_beat(make_beat(vwna_pkg::OP_RECORD, 32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000,
                        16'h0001, 10'd0));
    send_beat(make_beat(vwna_pkg::OP_RECORD, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001,
                        16'h4000, 16'hC000, 16'h0003, 10'd0));
    send_beat(make_beat(vwna_pkg::OP_RECORD, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001,
                        16'hC001, 16'h0001, 16'hFFFC, 10'd0));
    send_beat(make_beat(vwna_pkg::OP_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF));
    send_beat(make_beat(vwna_pkg::OP_RECORD, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001,
                        16'h0005, 16'hFFFB, 16'h0002, 10'd0));
    for (int i = 0; i < 5; i++)
      send_beat(make_beat(vwna_pkg::OP_READ, $urandom, $urandom, $urandom,
                          16'h0, 16'h0, 16'h0, 10'(i)));
    send_beat(make_beat(vwna_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
                        10'h3FF));
    send_beat(make_beat(vwna_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
                        10'h200));
    send_beat(make_beat(vwna_pkg::OP_NONE, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
                        10'd0));
    send_beat(make_beat(vwna_pkg::OP_CLEAR, $urandom, $urandom, $urandom, 16'h1, 16'h1,
                        16'h1, 10'd1));
    send_beat(make_beat(vwna_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
                        10'd0));
    send_beat(make_beat(vwna_pkg::OP_RECORD, 32'h0, 32'h0, 32'h0, 16'h1234, 16'h8001,
                        16'h7FFE, 10'd0));
    send_beat(make_beat(vwna_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
                        10'd0));
    drain();
  endtask

  // Receiver holds off while beats keep coming, so the input stalls
  task automatic test_backpressure;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 3000;
    for (int i = 0; i < 8; i++) send_beat(random_beat());
    drain();
  endtask

  task automatic test_random(input int beats, input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < beats; i++) send_beat(random_beat());
    drain();
  endtask

  initial begin
    for (int i = 0; i < 24; i++)
      for (int k = 0; k < 3; k++) pos_pool[i][k] = $urandom;
    fill_copy = 0;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_directed();
    test_random(138, 0, 0);
    test_random(138, 63, 0);
    test_backpressure();
    test_random(138, 0, 63);
    test_random(138, 10, 10);
    idle_pct  = 0;
    stall_pct = 0;
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
